// File: hdl/elg_pkg.sv
// ----------------------------------------------------------------------------
// ElGamal block cipher package
// Shared command and status types for the controller and the datapath,
// together with the register map and the register reset values.
// ----------------------------------------------------------------------------
package elg_pkg;

   // Register map of the configuration port.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIME   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GEN     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUBLIC  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIVATE = 2'd3;

   // Register values after reset.
   localparam int PRIME_RESET   = 11;
   localparam int GEN_RESET     = 2;
   localparam int PUBLIC_RESET  = 9;
   localparam int PRIVATE_RESET = 6;

   // Multiplicand sources of the modular multiplier (scanned bit by bit).
   typedef enum logic [2:0] {
      A_ACC,
      A_SQ,
      A_BLK,
      A_FACTOR,
      A_PRIV,
      A_ALPHA,
      A_PUBLIC,
      A_NONCE
   } mm_a_src_type;

   // Multiplier sources; the chosen value must not exceed the modulus.
   typedef enum logic [1:0] {
      B_ONE,
      B_SQ,
      B_FACTOR,
      B_ACC
   } mm_b_src_type;

   // Modulus of the operation: the prime, or the prime less one.
   typedef enum logic {
      M_P,
      M_PM1
   } mm_mod_type;

   // Where the product is written when the multiplier finishes.
   typedef enum logic [1:0] {
      D_ACC,
      D_SQ,
      D_EXP
   } mm_dst_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_item;
      logic         mm_start;
      mm_a_src_type a_src;
      mm_b_src_type b_src;
      mm_mod_type   mod_sel;
      mm_dst_type   dst;
      logic         acc_one;
      logic         exp_load;
      logic         exp_shift;
      logic         copy_share;
      logic         copy_factor;
      logic         clr_factor;
      logic         clr_share;
      logic         out_load;
      logic         out_zero;
   } elg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic decrypt;
      logic first;
      logic p_small;
      logic factor_lt_p;
      logic exp_bit;
      logic exp_zero;
      logic exp_rest_zero;
      logic mm_busy;
      logic mm_done;
      logic slot_free;
   } elg_status_type;

endpackage

// File: hdl/elg_datapath.sv
// ----------------------------------------------------------------------------
// ElGamal block cipher datapath
// Configuration registers, item registers, the stored factor and share, the
// exponentiation registers, a bit-serial modular multiplier and the output
// register.
// ----------------------------------------------------------------------------
module elg_datapath
   import elg_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]           csr_wdata,
   input  logic                       req_op,
   input  logic                       req_first_block,
   input  logic [WIDTH-1:0]           req_nonce_or_share,
   input  logic [WIDTH-1:0]           req_block_in,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [WIDTH-1:0]           rsp_block_out,
   output logic [WIDTH-1:0]           rsp_share_out,
   input  elg_cmd_type                cmd,
   output elg_status_type             status
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] p_ff, alpha_ff, public_ff, priv_ff;
   logic             op_ff, first_ff;
   logic [WIDTH-1:0] nonce_ff, blk_ff;
   logic [WIDTH-1:0] factor_ff, share_ff;
   logic [WIDTH-1:0] acc_ff, sq_ff, exp_ff;
   logic [WIDTH-1:0] mm_a_ff, mm_b_ff, mm_m_ff, mm_r_ff;
   mm_dst_type       mm_dst_ff;
   logic             mm_busy_ff;
   logic [CW-1:0]    mm_cnt_ff;
   logic             rsp_valid_ff;
   logic [WIDTH-1:0] rsp_block_ff, rsp_share_ff;

   logic [WIDTH-1:0] pm1;
   logic [WIDTH-1:0] a_sel, b_sel, m_sel;
   logic [WIDTH:0]   dbl, dbl_red, sum, sum_red, m_ext;
   logic [WIDTH-1:0] mm_res;
   logic             mm_done;
   logic             slot_free;

   assign pm1 = p_ff - WIDTH'(1);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff      <= WIDTH'(PRIME_RESET);
         alpha_ff  <= WIDTH'(GEN_RESET);
         public_ff <= WIDTH'(PUBLIC_RESET);
         priv_ff   <= WIDTH'(PRIVATE_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRIME:   p_ff      <= csr_wdata;
            CSR_GEN:     alpha_ff  <= csr_wdata;
            CSR_PUBLIC:  public_ff <= csr_wdata;
            CSR_PRIVATE: priv_ff   <= csr_wdata;
         endcase
      end
   end

   // Item registers, taken when the controller accepts an item.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= req_op;
         first_ff <= req_first_block;
         nonce_ff <= req_nonce_or_share;
         blk_ff   <= req_block_in;
      end
   end

   // Operand selection for a new multiplication.
   always_comb begin
      unique case (cmd.a_src)
         A_ACC:    a_sel = acc_ff;
         A_SQ:     a_sel = sq_ff;
         A_BLK:    a_sel = blk_ff;
         A_FACTOR: a_sel = factor_ff;
         A_PRIV:   a_sel = priv_ff;
         A_ALPHA:  a_sel = alpha_ff;
         A_PUBLIC: a_sel = public_ff;
         A_NONCE:  a_sel = nonce_ff;
      endcase
      unique case (cmd.b_src)
         B_ONE:    b_sel = WIDTH'(1);
         B_SQ:     b_sel = sq_ff;
         B_FACTOR: b_sel = factor_ff;
         B_ACC:    b_sel = acc_ff;
      endcase
      unique case (cmd.mod_sel)
         M_P:   m_sel = p_ff;
         M_PM1: m_sel = pm1;
      endcase
   end

   // One step of interleaved modular multiplication, multiplicand MSB first:
   // the remainder is doubled and reduced, then the multiplier is added when
   // the current bit is set and the sum is reduced again.
   always_comb begin
      m_ext   = {1'b0, mm_m_ff};
      dbl     = {mm_r_ff, 1'b0};
      dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
      sum     = dbl_red + (mm_a_ff[WIDTH-1] ? {1'b0, mm_b_ff} : '0);
      sum_red = (sum >= m_ext) ? sum - m_ext : sum;
      mm_res  = sum_red[WIDTH-1:0];
   end

   assign mm_done = mm_busy_ff && (mm_cnt_ff == CW'(1));

   // Multiplier control.
   always_ff @(posedge clock) begin
      if (reset) begin
         mm_busy_ff <= 1'b0;
      end else if (cmd.mm_start) begin
         mm_busy_ff <= 1'b1;
      end else if (mm_done) begin
         mm_busy_ff <= 1'b0;
      end
   end

   // Multiplier operands and running remainder.
   always_ff @(posedge clock) begin
      if (cmd.mm_start) begin
         mm_a_ff   <= a_sel;
         mm_b_ff   <= b_sel;
         mm_m_ff   <= m_sel;
         mm_r_ff   <= '0;
         mm_dst_ff <= cmd.dst;
         mm_cnt_ff <= CW'(WIDTH);
      end else if (mm_busy_ff) begin
         mm_a_ff   <= {mm_a_ff[WIDTH-2:0], 1'b0};
         mm_r_ff   <= mm_res;
         mm_cnt_ff <= mm_cnt_ff - CW'(1);
      end
   end

   // Accumulator and square of the exponentiation; the accumulator also
   // holds the product of the block.
   always_ff @(posedge clock) begin
      if (cmd.acc_one) begin
         acc_ff <= WIDTH'(1);
      end else if (mm_done && (mm_dst_ff == D_ACC)) begin
         acc_ff <= mm_res;
      end
      if (mm_done && (mm_dst_ff == D_SQ)) begin
         sq_ff <= mm_res;
      end
   end

   // Exponent register, consumed from its least significant bit.
   always_ff @(posedge clock) begin
      priority if (mm_done && (mm_dst_ff == D_EXP)) begin
         exp_ff <= pm1 - mm_res;
      end else if (cmd.exp_load) begin
         exp_ff <= nonce_ff;
      end else if (cmd.exp_shift) begin
         exp_ff <= {1'b0, exp_ff[WIDTH-1:1]};
      end
   end

   // Stored factor and share of the current message.
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= '0;
         share_ff  <= '0;
      end else begin
         if (cmd.clr_factor) begin
            factor_ff <= '0;
         end else if (cmd.copy_factor) begin
            factor_ff <= acc_ff;
         end
         if (cmd.clr_share) begin
            share_ff <= '0;
         end else if (cmd.copy_share) begin
            share_ff <= acc_ff;
         end
      end
   end

   // Output register; it frees as soon as the waiting item is taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_block_ff <= cmd.out_zero ? '0 : acc_ff;
         rsp_share_ff <= (cmd.out_zero || op_ff) ? '0 : share_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;
   assign rsp_share_out = rsp_share_ff;

   // Status towards the controller.
   always_comb begin
      status.decrypt       = op_ff;
      status.first         = first_ff;
      status.p_small       = (p_ff[WIDTH-1:1] == '0);
      status.factor_lt_p   = (factor_ff < p_ff);
      status.exp_bit       = exp_ff[0];
      status.exp_zero      = (exp_ff == '0);
      status.exp_rest_zero = (exp_ff[WIDTH-1:1] == '0);
      status.mm_busy       = mm_busy_ff;
      status.mm_done       = mm_done;
      status.slot_free     = slot_free;
   end

endmodule

// File: hdl/elg_ctrl.sv
// ----------------------------------------------------------------------------
// ElGamal block cipher controller
// Sequences the exponentiations of a first block and the block product,
// issuing one multiplier operation at a time to the datapath.
// ----------------------------------------------------------------------------
module elg_ctrl
   import elg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  elg_status_type status,
   output elg_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_WAIT,
      S_POW_BASE,
      S_POW_STEP,
      S_POW_SQR,
      S_POW_NEXT,
      S_POW_DONE,
      S_BLOCK,
      S_BLOCK_RED,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic      mask_pass_ff, mask_pass_in;

   // State, return point after a multiplication and exponentiation pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         mask_pass_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         mask_pass_ff <= mask_pass_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      mask_pass_in = mask_pass_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.p_small) begin
               // No field: the result is zero and a first block clears state.
               cmd.clr_factor = status.first;
               cmd.clr_share  = status.first && !status.decrypt;
               state_in       = S_FINISH;
            end else if (!status.first) begin
               state_in = S_BLOCK;
            end else if (status.decrypt) begin
               // Exponent is (p-1) - (a mod (p-1)).
               cmd.mm_start = 1'b1;
               cmd.a_src    = A_PRIV;
               cmd.b_src    = B_ONE;
               cmd.mod_sel  = M_PM1;
               cmd.dst      = D_EXP;
               mask_pass_in = 1'b1;
               ret_in       = S_POW_BASE;
               state_in     = S_WAIT;
            end else begin
               cmd.exp_load = 1'b1;
               mask_pass_in = 1'b0;
               state_in     = S_POW_BASE;
            end
         end
         S_WAIT: begin
            if (status.mm_done) begin
               state_in = ret_ff;
            end
         end
         S_POW_BASE: begin
            // Reduce the base into the square register and set acc to one.
            cmd.mm_start = 1'b1;
            priority if (status.decrypt) begin
               cmd.a_src = A_NONCE;
            end else if (mask_pass_ff) begin
               cmd.a_src = A_PUBLIC;
            end else begin
               cmd.a_src = A_ALPHA;
            end
            cmd.b_src   = B_ONE;
            cmd.mod_sel = M_P;
            cmd.dst     = D_SQ;
            cmd.acc_one = 1'b1;
            ret_in      = S_POW_STEP;
            state_in    = S_WAIT;
         end
         S_POW_STEP: begin
            priority if (status.exp_zero) begin
               state_in = S_POW_DONE;
            end else if (status.exp_bit) begin
               cmd.mm_start = 1'b1;
               cmd.a_src    = A_ACC;
               cmd.b_src    = B_SQ;
               cmd.mod_sel  = M_P;
               cmd.dst      = D_ACC;
               ret_in       = S_POW_SQR;
               state_in     = S_WAIT;
            end else begin
               state_in = S_POW_SQR;
            end
         end
         S_POW_SQR: begin
            // The square is skipped once no exponent bits remain.
            if (status.exp_rest_zero) begin
               state_in = S_POW_DONE;
            end else begin
               cmd.mm_start = 1'b1;
               cmd.a_src    = A_SQ;
               cmd.b_src    = B_SQ;
               cmd.mod_sel  = M_P;
               cmd.dst      = D_SQ;
               ret_in       = S_POW_NEXT;
               state_in     = S_WAIT;
            end
         end
         S_POW_NEXT: begin
            cmd.exp_shift = 1'b1;
            state_in      = S_POW_STEP;
         end
         S_POW_DONE: begin
            if (!status.decrypt && !mask_pass_ff) begin
               // Share done; the mask follows with the same nonce.
               cmd.copy_share = 1'b1;
               cmd.exp_load   = 1'b1;
               mask_pass_in   = 1'b1;
               state_in       = S_POW_BASE;
            end else begin
               cmd.copy_factor = 1'b1;
               state_in        = S_BLOCK;
            end
         end
         S_BLOCK: begin
            cmd.mm_start = 1'b1;
            cmd.mod_sel  = M_P;
            cmd.dst      = D_ACC;
            if (status.factor_lt_p) begin
               cmd.a_src = A_BLK;
               cmd.b_src = B_FACTOR;
               ret_in    = S_FINISH;
            end else begin
               // The prime changed since the factor was made: reduce it first.
               cmd.a_src = A_FACTOR;
               cmd.b_src = B_ONE;
               ret_in    = S_BLOCK_RED;
            end
            state_in = S_WAIT;
         end
         S_BLOCK_RED: begin
            cmd.mm_start = 1'b1;
            cmd.a_src    = A_BLK;
            cmd.b_src    = B_ACC;
            cmd.mod_sel  = M_P;
            cmd.dst      = D_ACC;
            ret_in       = S_FINISH;
            state_in     = S_WAIT;
         end
         S_FINISH: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = status.p_small;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/elgamal_block_cipher_core.sv
// ----------------------------------------------------------------------------
// ElGamal block cipher core
// Top level: controller and datapath of the block-wise ElGamal cipher.
// ----------------------------------------------------------------------------
// One item is worked on at a time, and the next is accepted while a finished
// result still waits in the output register. All modular arithmetic runs on
// one bit-serial multiplier. A block that is not the first of a message needs
// one product, or two when the stored factor is not below the prime, as after
// a change of the prime. A first block adds its exponentiations. Each one
// starts with the reduction of the base. Every exponent bit up to the highest
// set one adds a multiply when it is set. Every bit below the highest set one
// adds a square and the shift. Encryption runs two of them. Decryption runs
// one, after the private exponent is reduced.
module elgamal_block_cipher_core
   import elg_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]           csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic                       req_first_block,
   input  logic [WIDTH-1:0]           req_nonce_or_share,
   input  logic [WIDTH-1:0]           req_block_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [WIDTH-1:0]           rsp_block_out,
   output logic [WIDTH-1:0]           rsp_share_out
);

   elg_cmd_type    cmd;
   elg_status_type status;

   // Sequencer.
   elg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers and arithmetic.
   elg_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_op             (req_op),
      .req_first_block    (req_first_block),
      .req_nonce_or_share (req_nonce_or_share),
      .req_block_in       (req_block_in),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_block_out      (rsp_block_out),
      .rsp_share_out      (rsp_share_out),
      .cmd                (cmd),
      .status             (status)
   );

`ifndef ASSERT_OFF
   // A new multiplication never starts over one that is still running.
   assert property (@(posedge clock) disable iff (reset)
      cmd.mm_start |-> !status.mm_busy)
      else $error("multiplier started while busy");

   // A result is only loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.slot_free)
      else $error("result loaded over a waiting item");

   // An accepted item holds off intake until its result is loaded.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in work");

   // A loaded result is offered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not offered");
`endif

endmodule

// File: dv/elgamal_block_cipher_core_test.sv
// ----------------------------------------------------------------------------
// ElGamal block cipher core testbench
// Drives message blocks through the core under several register settings.
// Each accepted item is predicted in the bench and checked against the
// results as they arrive. Both channels idle at random, and the sender
// pauses at times until every outstanding result has been returned.
// ----------------------------------------------------------------------------
module elgamal_block_cipher_core_test;
   import elg_pkg::*;

   localparam int DATA_W = 16;

   // Operation codes of the op field.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] block_out;
      logic [DATA_W-1:0] share_out;
   } cipher_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [DATA_W-1:0]          csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_op = OP_ENCRYPT;
   logic                       req_first_block = 1'b0;
   logic [DATA_W-1:0]          req_nonce_or_share = '0;
   logic [DATA_W-1:0]          req_block_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   logic [DATA_W-1:0]          rsp_block_out;
   logic [DATA_W-1:0]          rsp_share_out;

   // Register copies and cipher state of the predictor.
   logic [DATA_W-1:0] cfg_prime;
   logic [DATA_W-1:0] cfg_gen;
   logic [DATA_W-1:0] cfg_public;
   logic [DATA_W-1:0] cfg_private;
   logic [DATA_W-1:0] mask_factor;
   logic [DATA_W-1:0] gamma_value;

   cipher_result_type expected_results[$];
   int                error_count = 0;
   bit                sender_idle_on = 1'b1;
   bit                receiver_idle_on = 1'b1;

   elgamal_block_cipher_core #(
      .WIDTH(DATA_W)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_first_block    (req_first_block),
      .req_nonce_or_share (req_nonce_or_share),
      .req_block_in       (req_block_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_block_out      (rsp_block_out),
      .rsp_share_out      (rsp_share_out)
   );

   // Clock generation.
   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: the slowest correct run is far shorter than this.
   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   // Modular power by right-to-left square-and-multiply over all exponent bits.
   function automatic logic [DATA_W-1:0] mod_power(input logic [DATA_W-1:0] base,
                                                   input logic [DATA_W-1:0] ex,
                                                   input logic [DATA_W-1:0] m);
      longint unsigned modulus;
      longint unsigned acc;
      longint unsigned sq;
      modulus = m;
      acc = 64'd1 % modulus;
      sq = base % modulus;
      for (int i = 0; i < DATA_W; i++) begin
         if (ex[i]) acc = (acc * sq) % modulus;
         sq = (sq * sq) % modulus;
      end
      return acc[DATA_W-1:0];
   endfunction

   // Works out the result of one block and updates the stored factor and share.
   function automatic cipher_result_type cipher_block(input logic op, input logic first,
                                                      input logic [DATA_W-1:0] share_in,
                                                      input logic [DATA_W-1:0] blk);
      cipher_result_type res;
      longint unsigned   p;
      longint unsigned   pm1;
      longint unsigned   ex;
      p = cfg_prime;
      res = '0;
      // Without a field every result is zero.
      if (p < 2) begin
         if (first) begin
            mask_factor = '0;
            if (op == OP_ENCRYPT) gamma_value = '0;
         end
         return res;
      end
      if (first) begin
         if (op == OP_DECRYPT) begin
            pm1 = p - 1;
            ex = pm1 - (longint'(cfg_private) % pm1);
            mask_factor = mod_power(share_in, ex[DATA_W-1:0], cfg_prime);
         end else begin
            gamma_value = mod_power(cfg_gen, share_in, cfg_prime);
            mask_factor = mod_power(cfg_public, share_in, cfg_prime);
         end
      end
      ex = ((longint'(blk) % p) * (longint'(mask_factor) % p)) % p;
      res.block_out = ex[DATA_W-1:0];
      res.share_out = (op == OP_DECRYPT) ? '0 : gamma_value;
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("error: %s", msg);
      error_count++;
   endtask

   // Sends one item after a random gap and records its expected result.
   task automatic send_block(input logic op, input logic first,
                             input logic [DATA_W-1:0] share_in,
                             input logic [DATA_W-1:0] blk,
                             output cipher_result_type res);
      int gap;
      gap = sender_idle_on ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_first_block    <= first;
      req_nonce_or_share <= share_in;
      req_block_in       <= blk;
      do @(posedge clock); while (!req_ready);
      res = cipher_block(op, first, share_in, blk);
      expected_results.push_back(res);
   endtask

   // Sends one item whose prediction is not needed afterwards.
   task automatic push_block(input logic op, input logic first,
                             input logic [DATA_W-1:0] share_in,
                             input logic [DATA_W-1:0] blk);
      cipher_result_type res;
      send_block(op, first, share_in, blk, res);
   endtask

   // Holds the sender back until every outstanding result has come.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PRIME:   cfg_prime = value;
         CSR_GEN:     cfg_gen = value;
         CSR_PUBLIC:  cfg_public = value;
         CSR_PRIVATE: cfg_private = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Writes the whole register set once the core is idle.
   task automatic load_settings(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] g,
                                input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] a);
      wait_for_results();
      write_register(CSR_PRIME, p);
      write_register(CSR_GEN, g);
      write_register(CSR_PUBLIC, x);
      write_register(CSR_PRIVATE, a);
   endtask

   // Result checker: each result is compared with the oldest expectation.
   initial begin
      cipher_result_type want;
      int                stall;
      wait (reset == 1'b0);
      forever begin
         stall = receiver_idle_on ? $urandom_range(0, 11) : 0;
         if (stall != 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (expected_results.size() == 0) begin
            report_error($sformatf("result %h/%h with no item outstanding",
                                   rsp_block_out, rsp_share_out));
         end else begin
            want = expected_results.pop_front();
            if (rsp_block_out !== want.block_out)
               report_error($sformatf("block_out %h, expected %h",
                                      rsp_block_out, want.block_out));
            if (rsp_share_out !== want.share_out)
               report_error($sformatf("share_out %h, expected %h",
                                      rsp_share_out, want.share_out));
         end
      end
   end

   // Reset settings: blocks before any first block, nonce zero, wide operands.
   task automatic test_reset_state();
      push_block(OP_ENCRYPT, 1'b0, 16'h1234, 16'd5);
      push_block(OP_DECRYPT, 1'b0, 16'h0000, 16'd7);
      push_block(OP_ENCRYPT, 1'b1, 16'h0000, 16'hFFFF);
      push_block(OP_ENCRYPT, 1'b0, 16'hABCD, 16'h0000);
      push_block(OP_ENCRYPT, 1'b1, 16'hFFFF, 16'd10);
      push_block(OP_DECRYPT, 1'b1, 16'hFFFF, 16'hFFFF);
      push_block(OP_DECRYPT, 1'b0, 16'h5555, 16'd3);
      push_block(OP_DECRYPT, 1'b1, 16'h0000, 16'd7);
      // A decrypt first block leaves the share of the last encryption alone.
      push_block(OP_ENCRYPT, 1'b0, 16'h0000, 16'd9);
   endtask

   // Largest primes and moduli, operands and exponents at their extremes.
   task automatic test_edge_values();
      load_settings(16'd65521, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_block(OP_ENCRYPT, 1'b1, 16'hFFFF, 16'hFFFF);
      push_block(OP_ENCRYPT, 1'b0, 16'h0000, 16'h0000);
      push_block(OP_DECRYPT, 1'b1, 16'hFFFF, 16'hFFFF);
      push_block(OP_DECRYPT, 1'b0, 16'h0000, 16'd65520);
      load_settings(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      push_block(OP_ENCRYPT, 1'b1, 16'h8000, 16'hFFFE);
      push_block(OP_DECRYPT, 1'b1, 16'h0000, 16'h7FFF);
      push_block(OP_DECRYPT, 1'b1, 16'h0001, 16'hFFFF);
   endtask

   // The prime changes in the middle of a message.
   task automatic test_prime_change();
      load_settings(16'd65521, 16'd17, 16'd40000, 16'd123);
      push_block(OP_ENCRYPT, 1'b1, 16'h3C5A, 16'd999);
      wait_for_results();
      write_register(CSR_PRIME, 16'd13);
      push_block(OP_ENCRYPT, 1'b0, 16'h0000, 16'd12);
      push_block(OP_DECRYPT, 1'b0, 16'h0000, 16'hFFFF);
   endtask

   // Moduli of zero and one give no field; two is the smallest field.
   task automatic test_degenerate_prime();
      load_settings(16'd0, 16'd2, 16'd9, 16'd6);
      push_block(OP_ENCRYPT, 1'b1, 16'd5, 16'd5);
      push_block(OP_DECRYPT, 1'b1, 16'd5, 16'd5);
      push_block(OP_ENCRYPT, 1'b0, 16'd5, 16'd5);
      wait_for_results();
      write_register(CSR_PRIME, 16'd1);
      push_block(OP_ENCRYPT, 1'b0, 16'd0, 16'hFFFF);
      wait_for_results();
      write_register(CSR_PRIME, 16'd2);
      push_block(OP_ENCRYPT, 1'b1, 16'd3, 16'hFFFF);
      push_block(OP_DECRYPT, 1'b1, 16'd1, 16'hFFFF);
   endtask

   function automatic logic [DATA_W-1:0] pick_prime();
      logic [DATA_W-1:0] primes[13] = '{16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13,
                                        16'd17, 16'd251, 16'd257, 16'd4099,
                                        16'd32749, 16'd65519, 16'd65521};
      int sel;
      sel = $urandom_range(0, 11);
      if (sel == 0) return DATA_W'($urandom_range(0, 1));
      if (sel == 1) return DATA_W'($urandom_range(0, 65535));
      return primes[$urandom_range(0, 12)];
   endfunction

   // Draws a block, mostly inside the field and sometimes over the whole width.
   function automatic logic [DATA_W-1:0] pick_block();
      if (cfg_prime < 2 || $urandom_range(0, 3) == 0)
         return DATA_W'($urandom_range(0, 65535));
      return DATA_W'($urandom_range(0, cfg_prime - 1));
   endfunction

   // Random settings, then mostly whole messages and their decryption, some noise.
   task automatic test_random_messages();
      logic [DATA_W-1:0] p;
      logic [DATA_W-1:0] g;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] x;
      cipher_result_type sent[8];
      int                count;
      int                len;
      for (int phase = 0; phase < 10; phase++) begin
         p = pick_prime();
         g = (p >= 2 && $urandom_range(0, 3) != 0) ? DATA_W'($urandom_range(1, p - 1))
                                                    : DATA_W'($urandom_range(0, 65535));
         a = (p >= 3 && $urandom_range(0, 3) != 0) ? DATA_W'($urandom_range(0, p - 2))
                                                    : DATA_W'($urandom_range(0, 65535));
         x = (p >= 2 && $urandom_range(0, 3) != 0) ? mod_power(g, a, p)
                                                    : DATA_W'($urandom_range(0, 65535));
         load_settings(p, g, x, a);
         sender_idle_on = (phase % 3 != 1);
         receiver_idle_on = (phase % 3 != 2);
         count = 0;
         while (count < 100) begin
            if ($urandom_range(0, 9) < 6) begin
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++)
                  send_block(OP_ENCRYPT, i == 0, DATA_W'($urandom_range(0, 65535)),
                             pick_block(), sent[i]);
               count += len;
               // Decrypt the message just sent, with its own share and deltas.
               if ($urandom_range(0, 9) < 7) begin
                  for (int i = 0; i < len; i++)
                     push_block(OP_DECRYPT, i == 0, sent[0].share_out, sent[i].block_out);
                  count += len;
               end
            end else begin
               push_block(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                          DATA_W'($urandom_range(0, 65535)),
                          DATA_W'($urandom_range(0, 65535)));
               count++;
            end
            if ($urandom_range(0, 9) == 0) wait_for_results();
         end
      end
   endtask

   // Test sequence.
   initial begin
      cfg_prime   = DATA_W'(PRIME_RESET);
      cfg_gen     = DATA_W'(GEN_RESET);
      cfg_public  = DATA_W'(PUBLIC_RESET);
      cfg_private = DATA_W'(PRIVATE_RESET);
      mask_factor = '0;
      gamma_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_edge_values();
      test_prime_change();
      test_degenerate_prime();
      test_random_messages();

      wait_for_results();
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/elg_pkg.sv
hdl/elg_datapath.sv
hdl/elg_ctrl.sv
hdl/elgamal_block_cipher_core.sv
dv/elgamal_block_cipher_core_test.sv
